### rtl/rspw_pkg.sv
// ----------------------------------------------------------------------------
// rspw_pkg
// Shared types and constants of the RAID-5 stripe parity writer: register
// codes, reset values, and the command and result records.
// ----------------------------------------------------------------------------
package rspw_pkg;

   // Default sizes for the top-level parameters.
   localparam int MAX_BLOCK_DEF   = 4096;
   localparam int MAX_DISK_DEF    = 32;
   localparam int MAX_STRIPES_DEF = 4096;

   // Fixed field widths.
   localparam int BB_W       = 13;  // block size register
   localparam int DC_W       = 6;   // disk count register
   localparam int SC_W       = 13;  // stripe count register
   localparam int DISK_W     = 5;   // disk number
   localparam int OFF_W      = 24;  // byte offset on a disk
   localparam int DATA_W     = 8;   // one payload byte
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Depths of the two queues.
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   // Register reset values.
   localparam logic [BB_W-1:0] BLOCK_BYTES_RST  = 13'd512;
   localparam logic [DC_W-1:0] DISK_COUNT_RST   = 6'd4;
   localparam logic [SC_W-1:0] STRIPE_COUNT_RST = 13'd1024;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_BYTES  = 2'd0,
      CSR_DISK_COUNT   = 2'd1,
      CSR_STRIPE_COUNT = 2'd2
   } csr_index_type;

   // One classified byte, handed from the front to the back.
   typedef struct packed {
      logic              ovf;        // array full, byte dropped
      logic              first;      // byte of the stripe's first data block
      logic              last;       // byte of the stripe's last data block
      logic [DATA_W-1:0] data;
      logic [DISK_W-1:0] data_disk;
      logic [DISK_W-1:0] par_disk;
      logic [OFF_W-1:0]  offset;
      logic [BB_W-1:0]   pos;        // byte within the block
   } cmd_type;

   // One result beat.
   typedef struct packed {
      logic [DISK_W-1:0] disk_index;
      logic [OFF_W-1:0]  byte_offset;
      logic [DATA_W-1:0] write_value;
      logic              is_parity;
      logic              overflow;
      logic              last_of_run;
   } rsp_type;

endpackage

### rtl/raid5_stripe_parity_writer_unit.sv
// ----------------------------------------------------------------------------
// raid5_stripe_parity_writer_unit
// Places a byte stream on a RAID-5 array with rotating parity and issues the
// XOR parity byte alongside each byte of a stripe's last data block.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_push / req_full  req_data_byte
//   rsp_      out        rsp_pop / rsp_empty  disk, offset, value, flags
//   csr_      in         csr_we               csr_index, csr_wdata
//
// A byte is accepted every cycle while the command queue has room. The back
// end issues one result beat per cycle while the result queue has room, so
// bytes of a stripe's last data block take two beats there and all others one.
// A byte passes through the command queue, the back end's execute stage and
// the result queue before its first result beat reaches the result port.
// Reset is synchronous; the parity buffer needs no clearing pass.
// A stalled result port fills the result queue, then the command queue,
// then raises req_full.
// ----------------------------------------------------------------------------
module raid5_stripe_parity_writer_unit #(
   parameter int MAX_BLOCK   = rspw_pkg::MAX_BLOCK_DEF,
   parameter int MAX_DISK    = rspw_pkg::MAX_DISK_DEF,
   parameter int MAX_STRIPES = rspw_pkg::MAX_STRIPES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input byte stream
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [rspw_pkg::DATA_W-1:0]      req_data_byte,
   // Write results
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [rspw_pkg::DISK_W-1:0]      rsp_disk_index,
   output logic [rspw_pkg::OFF_W-1:0]       rsp_byte_offset,
   output logic [rspw_pkg::DATA_W-1:0]      rsp_write_value,
   output logic                             rsp_is_parity,
   output logic                             rsp_overflow,
   output logic                             rsp_last_of_run,
   // Configuration
   input  logic                             csr_we,
   input  logic [rspw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rspw_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CMD_W = $bits(rspw_pkg::cmd_type);
   localparam int RSP_W = $bits(rspw_pkg::rsp_type);

   rspw_pkg::cmd_type front_cmd, head_cmd;
   rspw_pkg::rsp_type back_rsp, out_rsp;
   logic              accept;
   logic              cmd_empty, cmd_pop;
   logic              rsp_q_full, rsp_push;

   assign accept = req_push && !req_full;

   // Front: registers, position, classification.
   rspw_front #(
      .MAX_BLOCK   (MAX_BLOCK),
      .MAX_DISK    (MAX_DISK),
      .MAX_STRIPES (MAX_STRIPES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .data_byte (req_data_byte),
      .cmd       (front_cmd)
   );

   // Command queue between front and back.
   rspw_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (rspw_pkg::CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (head_cmd),
      .empty     (cmd_empty)
   );

   // Back: parity buffer and result beats.
   rspw_back #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_q_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   // Result queue in front of the output port.
   rspw_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (rspw_pkg::RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_q_full),
      .pop       (rsp_pop),
      .pop_data  (out_rsp),
      .empty     (rsp_empty)
   );

   assign rsp_disk_index  = out_rsp.disk_index;
   assign rsp_byte_offset = out_rsp.byte_offset;
   assign rsp_write_value = out_rsp.write_value;
   assign rsp_is_parity   = out_rsp.is_parity;
   assign rsp_overflow    = out_rsp.overflow;
   assign rsp_last_of_run = out_rsp.last_of_run;

endmodule

### rtl/rspw_fifo.sv
// ----------------------------------------------------------------------------
// rspw_fifo
// Small first-in first-out queue of register slots, used between the front
// and the back and again in front of the result port.
// ----------------------------------------------------------------------------
module rspw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/rspw_front.sv
// ----------------------------------------------------------------------------
// rspw_front
// Holds the configuration registers and the stripe position. Classifies each
// accepted byte (overflow, first or last data block), works out its disks and
// offset, and advances the layout position.
// ----------------------------------------------------------------------------
module rspw_front #(
   parameter int MAX_BLOCK   = rspw_pkg::MAX_BLOCK_DEF,
   parameter int MAX_DISK    = rspw_pkg::MAX_DISK_DEF,
   parameter int MAX_STRIPES = rspw_pkg::MAX_STRIPES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rspw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rspw_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              accept,
   input  logic [rspw_pkg::DATA_W-1:0]       data_byte,
   output rspw_pkg::cmd_type                 cmd
);

   localparam int BB_W   = rspw_pkg::BB_W;
   localparam int DC_W   = rspw_pkg::DC_W;
   localparam int SC_W   = rspw_pkg::SC_W;
   localparam int DISK_W = rspw_pkg::DISK_W;
   localparam int OFF_W  = rspw_pkg::OFF_W;

   // Configuration registers.
   logic [BB_W-1:0] block_ff, block_in;
   logic [DC_W-1:0] disks_ff, disks_in;
   logic [SC_W-1:0] stripes_ff, stripes_in;

   // Layout position.
   logic [BB_W-1:0]   byte_ff, byte_in;
   logic [DISK_W-1:0] dblk_ff, dblk_in;
   logic [SC_W-1:0]   stripe_ff, stripe_in;
   logic [DISK_W-1:0] pdisk_ff, pdisk_in;
   logic [DISK_W-1:0] ddisk_ff, ddisk_in;
   logic [OFF_W-1:0]  base_ff, base_in;

   logic              restart;
   logic              ovf, blk_end, stripe_end;
   logic [BB_W-1:0]   byte_nx;
   logic [DC_W-1:0]   dblk_plus2;
   logic [DISK_W-1:0] pdisk_nx;

   // Classification of the byte at the input.
   assign ovf        = (stripe_ff >= stripes_ff);
   assign dblk_plus2 = {1'b0, dblk_ff} + DC_W'(2);
   assign byte_nx    = byte_ff + 1'b1;
   assign blk_end    = (byte_nx >= block_ff);
   assign stripe_end = (dblk_plus2 >= disks_ff);
   assign pdisk_nx   = (pdisk_ff == '0) ? DISK_W'(disks_ff - 1'b1) : pdisk_ff - 1'b1;

   always_comb begin
      cmd.ovf       = ovf;
      cmd.first     = (dblk_ff == '0);
      cmd.last      = (dblk_plus2 == disks_ff);
      cmd.data      = data_byte;
      cmd.data_disk = ddisk_ff;
      cmd.par_disk  = pdisk_ff;
      cmd.offset    = base_ff + OFF_W'(byte_ff);
      cmd.pos       = byte_ff;
   end

   // Register writes with clamping; any known index restarts the stream.
   always_comb begin
      block_in   = block_ff;
      disks_in   = disks_ff;
      stripes_in = stripes_ff;
      restart    = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            rspw_pkg::CSR_BLOCK_BYTES: begin
               restart = 1'b1;
               if (csr_wdata == '0) begin
                  block_in = BB_W'(1);
               end else if (32'(csr_wdata) > MAX_BLOCK) begin
                  block_in = BB_W'(MAX_BLOCK);
               end else begin
                  block_in = BB_W'(csr_wdata);
               end
            end
            rspw_pkg::CSR_DISK_COUNT: begin
               restart = 1'b1;
               if (32'(csr_wdata) < 2) begin
                  disks_in = DC_W'(2);
               end else if (32'(csr_wdata) > MAX_DISK) begin
                  disks_in = DC_W'(MAX_DISK);
               end else begin
                  disks_in = DC_W'(csr_wdata);
               end
            end
            rspw_pkg::CSR_STRIPE_COUNT: begin
               restart = 1'b1;
               if (csr_wdata == '0) begin
                  stripes_in = SC_W'(1);
               end else if (32'(csr_wdata) > MAX_STRIPES) begin
                  stripes_in = SC_W'(MAX_STRIPES);
               end else begin
                  stripes_in = SC_W'(csr_wdata);
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // Position advance: byte, then data block, then stripe.
   always_comb begin
      byte_in   = byte_ff;
      dblk_in   = dblk_ff;
      stripe_in = stripe_ff;
      pdisk_in  = pdisk_ff;
      base_in   = base_ff;
      ddisk_in  = ddisk_ff;
      if (restart) begin
         byte_in   = '0;
         dblk_in   = '0;
         stripe_in = '0;
         pdisk_in  = DISK_W'(disks_in - 1'b1);
         base_in   = '0;
         ddisk_in  = '0;
      end else if (accept && !ovf) begin
         if (blk_end) begin
            byte_in = '0;
            if (stripe_end) begin
               dblk_in   = '0;
               stripe_in = stripe_ff + 1'b1;
               base_in   = base_ff + OFF_W'(block_ff);
               pdisk_in  = pdisk_nx;
            end else begin
               dblk_in = dblk_ff + 1'b1;
            end
            ddisk_in = (dblk_in < pdisk_in) ? dblk_in : dblk_in + 1'b1;
         end else begin
            byte_in = byte_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_ff   <= rspw_pkg::BLOCK_BYTES_RST;
         disks_ff   <= rspw_pkg::DISK_COUNT_RST;
         stripes_ff <= rspw_pkg::STRIPE_COUNT_RST;
         byte_ff    <= '0;
         dblk_ff    <= '0;
         stripe_ff  <= '0;
         pdisk_ff   <= DISK_W'(rspw_pkg::DISK_COUNT_RST - 1'b1);
         ddisk_ff   <= '0;
         base_ff    <= '0;
      end else begin
         block_ff   <= block_in;
         disks_ff   <= disks_in;
         stripes_ff <= stripes_in;
         byte_ff    <= byte_in;
         dblk_ff    <= dblk_in;
         stripe_ff  <= stripe_in;
         pdisk_ff   <= pdisk_in;
         ddisk_ff   <= ddisk_in;
         base_ff    <= base_in;
      end
   end

endmodule

### rtl/rspw_back.sv
// ----------------------------------------------------------------------------
// rspw_back
// Carries out classified bytes: reads and updates the block-deep parity
// buffer and issues the data beat (an overflow beat for a dropped byte) and,
// for the stripe's last data block, the parity beat that follows it.
// ----------------------------------------------------------------------------
module rspw_back #(
   parameter int MAX_BLOCK = rspw_pkg::MAX_BLOCK_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  rspw_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output rspw_pkg::rsp_type  rsp
);

   localparam int IDX_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int DATA_W = rspw_pkg::DATA_W;

   // Parity buffer; entries are always written by a stripe's first block
   // before later blocks read them.
   logic [DATA_W-1:0] par_mem [MAX_BLOCK];

   // Execute stage.
   logic              b_valid_ff, b_valid_in;
   logic              phase_ff, phase_in;
   rspw_pkg::cmd_type b_cmd_ff;
   logic [DATA_W-1:0] rdata_ff;
   logic              byp_ff;
   logic [DATA_W-1:0] byp_data_ff;

   logic [IDX_W-1:0]  head_idx, b_idx;
   logic [DATA_W-1:0] old_par, new_par;
   logic              wr_en, retire, load;

   assign head_idx = IDX_W'(cmd.pos);
   assign b_idx    = IDX_W'(b_cmd_ff.pos);

   // Parity merge, with a bypass for a write at the same edge as the read.
   assign old_par = byp_ff ? byp_data_ff : rdata_ff;
   assign new_par = b_cmd_ff.first ? b_cmd_ff.data : (old_par ^ b_cmd_ff.data);

   // Beat control: a beat a cycle unless rsp_full, a second for last-block bytes.
   assign rsp_push = b_valid_ff && !rsp_full;
   assign wr_en    = rsp_push && !phase_ff && !b_cmd_ff.ovf;
   assign retire   = rsp_push && (b_cmd_ff.ovf || !b_cmd_ff.last || phase_ff);
   assign load     = cmd_valid && (!b_valid_ff || retire);
   assign cmd_pop  = load;

   always_comb begin
      b_valid_in = b_valid_ff;
      phase_in   = phase_ff;
      if (load) begin
         b_valid_in = 1'b1;
      end else if (retire) begin
         b_valid_in = 1'b0;
      end
      if (retire) begin
         phase_in = 1'b0;
      end else if (rsp_push) begin
         phase_in = 1'b1;
      end
   end

   // Result beat contents.
   always_comb begin
      if (b_cmd_ff.ovf) begin
         rsp.disk_index  = '0;
         rsp.byte_offset = '0;
         rsp.write_value = '0;
         rsp.is_parity   = 1'b0;
         rsp.overflow    = 1'b1;
         rsp.last_of_run = 1'b1;
      end else if (!phase_ff) begin
         rsp.disk_index  = b_cmd_ff.data_disk;
         rsp.byte_offset = b_cmd_ff.offset;
         rsp.write_value = b_cmd_ff.data;
         rsp.is_parity   = 1'b0;
         rsp.overflow    = 1'b0;
         rsp.last_of_run = !b_cmd_ff.last;
      end else begin
         rsp.disk_index  = b_cmd_ff.par_disk;
         rsp.byte_offset = b_cmd_ff.offset;
         rsp.write_value = new_par;
         rsp.is_parity   = 1'b1;
         rsp.overflow    = 1'b0;
         rsp.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         phase_ff   <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         phase_ff   <= phase_in;
      end
   end

   // Stage payload and registered read of the parity buffer.
   always_ff @(posedge clock) begin
      if (load) begin
         b_cmd_ff    <= cmd;
         rdata_ff    <= par_mem[head_idx];
         byp_ff      <= wr_en && (b_idx == head_idx);
         byp_data_ff <= new_par;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         par_mem[b_idx] <= new_par;
      end
   end

   // The buffer is only written by a data beat of an item that is not an overflow.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (b_valid_ff && !phase_ff && !b_cmd_ff.ovf))
      else $error("parity buffer written outside a data beat");

   // The parity phase only exists for last-block items.
   a_phase_last: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (b_valid_ff && b_cmd_ff.last && !b_cmd_ff.ovf))
      else $error("parity phase without a last-block item");

   // A data beat of a last-block item is always followed by its parity beat.
   a_parity_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && !phase_ff && b_cmd_ff.last && !b_cmd_ff.ovf) |=> phase_ff)
      else $error("parity beat missing after last-block data beat");

   // No new item enters while a parity beat is still owed.
   a_no_load_owed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff && !rsp_push) |-> !load)
      else $error("item loaded over a pending parity beat");

endmodule
